// ===== design/me64_pkg.sv =====
// Shared types and constants for the 64-bit modular exponentiation block.
`timescale 1ns / 1ps
package me64_pkg;

   localparam int WORD_W = 64;
   localparam int CNT_W  = 6;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]  count_type;

   localparam count_type LAST_STEP = CNT_W'(WORD_W - 1);

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

// ===== design/me64_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
module me64_modmul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  me64_pkg::word_type      multiplier,
   input  me64_pkg::word_type      multiplicand,
   input  me64_pkg::word_type      modulus,
   output me64_pkg::word_type      product,
   output me64_pkg::mm_status_type status
);
   import me64_pkg::*;

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   word_type  mplr_ff, mplr_in;
   word_type  mcand_ff, mcand_in;
   word_type  acc_ff, acc_in;
   count_type count_ff, count_in;

   logic [WORD_W+1:0] sum_w;
   logic [WORD_W+1:0] n_ext;
   logic [WORD_W+1:0] n2_ext;
   word_type          step_acc;

   // acc < n and mcand < n, so 2*acc + mcand < 3n: one of three candidates.
   always_comb begin
      sum_w  = {1'b0, acc_ff, 1'b0}
             + (mplr_ff[WORD_W-1] ? {2'b00, mcand_ff} : {(WORD_W+2){1'b0}});
      n_ext  = {2'b00, modulus};
      n2_ext = {1'b0, modulus, 1'b0};
      priority if (sum_w >= n2_ext) begin
         step_acc = WORD_W'(sum_w - n2_ext);
      end else if (sum_w >= n_ext) begin
         step_acc = WORD_W'(sum_w - n_ext);
      end else begin
         step_acc = WORD_W'(sum_w);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         mplr_in  = multiplier;
         mcand_in = multiplicand;
         acc_in   = '0;
         count_in = '0;
      end else if (busy_ff) begin
         acc_in   = step_acc;
         mplr_in  = {mplr_ff[WORD_W-2:0], 1'b0};
         count_in = count_ff + count_type'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== design/modular_exponentiation_64.sv =====
// Top level: 64-bit modular exponentiation by right-to-left square and multiply.
//
// Usage:
//   Request channel (req_valid / req_stall) carries base, exponent and modulus.
//   req_stall is high while an item is in work; one item is in work at a time.
//   Result channel (rsp_valid / rsp_stall) carries power_result and
//   modulus_error from an output register; a stalled result holds steady.
// Sequence:
//   A zero exponent or zero modulus goes straight to the output state.
//   Otherwise the base is first reduced modulo the modulus, then each exponent
//   bit up to the highest set bit takes one square-and-multiply pass: two
//   bit-serial multipliers run the square and the multiply side by side, one
//   multiplier bit per cycle.
//   Items do not overlap; the next item is taken once the block is idle again.
// Reset:
//   Synchronous, active high; returns to idle and drops any pending result.
// Stall:
//   A finished result waits in the working state until the output register
//   is free; a new item is taken as soon as the block returns to idle, even
//   while the previous result is still held.
`timescale 1ns / 1ps
module modular_exponentiation_64 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  me64_pkg::word_type req_base_value,
   input  me64_pkg::word_type req_exponent_value,
   input  me64_pkg::word_type req_modulus_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output me64_pkg::word_type rsp_power_result,
   output logic               rsp_modulus_error
);
   import me64_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQMUL,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   logic      go_ff;
   logic      go_in;
   logic      rsp_valid_ff;
   word_type  rsp_power_result_ff;
   logic      rsp_modulus_error_ff;

   // Working registers: payload, no reset needed.
   word_type  e_ff;
   word_type  n_ff;
   word_type  b_ff;
   word_type  r_ff;
   logic      err_ff;

   word_type      mplr_a, mcand_a;
   word_type      prod_a, prod_b;
   mm_status_type stat_a, stat_b;
   word_type      e_next;
   logic          out_free;

   // Unit A reduces the base (base * 1 mod n), then forms r * b.
   // Unit B forms b * b.
   always_comb begin
      if (state_ff == ST_REDUCE) begin
         mplr_a  = b_ff;
         mcand_a = WORD_W'(1);
      end else begin
         mplr_a  = r_ff;
         mcand_a = b_ff;
      end
   end

   me64_modmul u_mul_a (
      .clock        (clock),
      .reset        (reset),
      .start        (go_ff),
      .multiplier   (mplr_a),
      .multiplicand (mcand_a),
      .modulus      (n_ff),
      .product      (prod_a),
      .status       (stat_a)
   );

   me64_modmul u_mul_b (
      .clock        (clock),
      .reset        (reset),
      .start        (go_ff),
      .multiplier   (b_ff),
      .multiplicand (b_ff),
      .modulus      (n_ff),
      .product      (prod_b),
      .status       (stat_b)
   );

   assign e_next   = {1'b0, e_ff[WORD_W-1:1]};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Launch both units for the base reduction and again for each exponent bit.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   go_in = req_valid && (req_exponent_value != '0)
                            && (req_modulus_value != '0);
         ST_REDUCE: go_in = stat_a.done;
         ST_SQMUL:  go_in = stat_a.done && stat_b.done && (e_next != '0);
         default:   go_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
         // load a new result, or drop the one just taken
         if (state_ff == ST_OUTPUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  e_ff <= req_exponent_value;
                  n_ff <= req_modulus_value;
                  b_ff <= req_base_value;
                  priority if (req_exponent_value == '0) begin
                     // zero exponent: 1, unreduced
                     r_ff     <= WORD_W'(1);
                     err_ff   <= 1'b0;
                     state_ff <= ST_OUTPUT;
                  end else if (req_modulus_value == '0) begin
                     r_ff     <= '0;
                     err_ff   <= 1'b1;
                     state_ff <= ST_OUTPUT;
                  end else begin
                     // start r at 1 mod n
                     r_ff     <= (req_modulus_value == WORD_W'(1)) ? '0 : WORD_W'(1);
                     err_ff   <= 1'b0;
                     state_ff <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               if (stat_a.done) begin
                  b_ff     <= prod_a;
                  state_ff <= ST_SQMUL;
               end
            end
            ST_SQMUL: begin
               // both units finish together; consume one exponent bit
               if (stat_a.done && stat_b.done) begin
                  if (e_ff[0]) begin
                     r_ff <= prod_a;
                  end
                  b_ff <= prod_b;
                  e_ff <= e_next;
                  if (e_next == '0) begin
                     state_ff <= ST_OUTPUT;
                  end
               end
            end
            ST_OUTPUT: begin
               // hold until the output register can take the item
               if (out_free) begin
                  rsp_power_result_ff  <= r_ff;
                  rsp_modulus_error_ff <= err_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_power_result  = rsp_power_result_ff;
   assign rsp_modulus_error = rsp_modulus_error_ff;

endmodule

// ===== design/me64_checker.sv =====
// Port-level checker for the modular exponentiation block, with its bind.
`timescale 1ns / 1ps
module me64_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input me64_pkg::word_type req_base_value,
   input me64_pkg::word_type req_exponent_value,
   input me64_pkg::word_type req_modulus_value,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input me64_pkg::word_type rsp_power_result,
   input logic               rsp_modulus_error
);
   import me64_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_base_value)
         && $stable(req_exponent_value) && $stable(req_modulus_value))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_power_result) && $stable(rsp_modulus_error))
      else $error("stalled result changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modulus_error |-> rsp_power_result == '0)
      else $error("modulus error with nonzero result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block idle right after taking an item");

endmodule

bind modular_exponentiation_64 me64_checker u_me64_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_base_value     (req_base_value),
   .req_exponent_value (req_exponent_value),
   .req_modulus_value  (req_modulus_value),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_power_result   (rsp_power_result),
   .rsp_modulus_error  (rsp_modulus_error)
);
